[rtl/cansd_pkg.sv]
// Package for the CAN signal decoder: the fixed signal table, outcome codes,
// register indexes and reset values of the limit registers.
// Depends on nothing; imported by can_signal_decoder.
package cansd_pkg;

  // Number of entries in the signal table.
  localparam int unsigned SlotCount = 5;

  // Field widths of the streaming items.
  localparam int unsigned IdentW  = 11;
  localparam int unsigned LengthW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned ValueW  = 20;
  localparam int unsigned RawW    = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 104;

  // Configuration port widths.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Result of decoding one frame.
  typedef enum logic [1:0] {
    OUTCOME_IN_RANGE  = 2'd0,
    OUTCOME_OUT_RANGE = 2'd1,
    OUTCOME_LEN_ERR   = 2'd2,
    OUTCOME_UNKNOWN   = 2'd3
  } outcome_e;

  // Signal slots, which are also the limit register indexes.
  typedef enum logic [2:0] {
    SLOT_RPM     = 3'd0,
    SLOT_SPEED   = 3'd1,
    SLOT_CHARGE  = 3'd2,
    SLOT_VOLTAGE = 3'd3,
    SLOT_TEMP    = 3'd4
  } slot_e;

  // Signal table: identifier, expected length, sixteen-bit raw, scale by ten.
  localparam logic [IdentW-1:0] TblId [SlotCount] = '{
    11'h101, 11'h102, 11'h103, 11'h104, 11'h105
  };
  localparam logic [LengthW-1:0] TblLen [SlotCount] = '{
    4'd2, 4'd2, 4'd1, 4'd2, 4'd1
  };
  localparam logic TblWide [SlotCount] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic TblX10  [SlotCount] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // Reset values of the limit registers.
  localparam logic [15:0] RpmLimitReset     = 16'd10000;
  localparam logic [15:0] SpeedLimitReset   = 16'd1200;
  localparam logic [7:0]  ChargeLimitReset  = 8'd100;
  localparam logic [15:0] VoltageLimitReset = 16'd1000;
  localparam logic [7:0]  TempLimitReset    = 8'd150;

endpackage

[rtl/can_signal_decoder.sv]
// Throughput: one frame per cycle; the input register and the result register form a
// two-stage pipeline that advances whenever the result register is empty or being taken.
// Reset (rst_ni, asynchronous, active low) empties both stages, clears the stored vehicle
// values and warning bits, and loads the limit registers with their default values.
module can_signal_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side: frame_ident [10:0], frame_length [14:11], first_byte [22:15],
  // second_byte [30:23], zero [31].
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cansd_pkg::InDataW-1:0]       s_axis_tdata,
  // Master side: outcome [1:0], signal_slot [4:2], value_tenths [24:5], rpm_now [44:25],
  // rpm_flag [45], speed_now [61:46], speed_flag [62], charge_now [74:63],
  // voltage_now [90:75], temp_now [102:91], zero [103].
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cansd_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cansd_pkg::AddrW-1:0]         paddr,
  input  logic [cansd_pkg::DataW-1:0]         pwdata,
  output logic [cansd_pkg::DataW-1:0]         prdata,
  output logic                                pready
);
  import cansd_pkg::*;

  // Configuration registers.
  logic [15:0] rpm_limit_q;
  logic [15:0] speed_limit_q;
  logic [7:0]  charge_limit_q;
  logic [15:0] voltage_limit_q;
  logic [7:0]  temp_limit_q;
  logic        cfg_write;
  logic [2:0]  cfg_idx;

  // Pipeline control.
  logic               in_valid_q;
  logic [IdentW-1:0]  ident_q;
  logic [LengthW-1:0] length_q;
  logic [ByteW-1:0]   byte0_q;
  logic [ByteW-1:0]   byte1_q;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic               out_free;
  logic               advance;

  // Stored vehicle values.
  logic [19:0] rpm_q, rpm_d;
  logic        rpm_warn_q, rpm_warn_d;
  logic [15:0] speed_q, speed_d;
  logic        speed_warn_q, speed_warn_d;
  logic [11:0] charge_q, charge_d;
  logic [15:0] voltage_q, voltage_d;
  logic [11:0] temp_q, temp_d;

  // Decode results.
  logic              match;
  logic [SlotW-1:0]  slot;
  logic              len_ok;
  logic [RawW-1:0]   raw;
  logic [RawW-1:0]   limit;
  logic              over;
  logic [ValueW-1:0] scaled;
  logic [ValueW-1:0] value;
  outcome_e          outcome;
  logic [OutDataW-1:0] result;

  // The configuration port always completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = paddr[4:2];

  // Limit registers are written by index; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_limit_q     <= RpmLimitReset;
      speed_limit_q   <= SpeedLimitReset;
      charge_limit_q  <= ChargeLimitReset;
      voltage_limit_q <= VoltageLimitReset;
      temp_limit_q    <= TempLimitReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        SLOT_RPM:     rpm_limit_q     <= pwdata[15:0];
        SLOT_SPEED:   speed_limit_q   <= pwdata[15:0];
        SLOT_CHARGE:  charge_limit_q  <= pwdata[7:0];
        SLOT_VOLTAGE: voltage_limit_q <= pwdata[15:0];
        SLOT_TEMP:    temp_limit_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      SLOT_RPM:     prdata = {16'd0, rpm_limit_q};
      SLOT_SPEED:   prdata = {16'd0, speed_limit_q};
      SLOT_CHARGE:  prdata = {24'd0, charge_limit_q};
      SLOT_VOLTAGE: prdata = {16'd0, voltage_limit_q};
      SLOT_TEMP:    prdata = {24'd0, temp_limit_q};
      default:      prdata = '0;
    endcase
  end

  // The input stage moves on when the result register is empty or being taken.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ident_q  <= s_axis_tdata[10:0];
      length_q <= s_axis_tdata[14:11];
      byte0_q  <= s_axis_tdata[22:15];
      byte1_q  <= s_axis_tdata[30:23];
    end
  end

  // Identifier lookup in the signal table; the first hit wins.
  always_comb begin
    match = 1'b0;
    slot  = SLOT_RPM;
    for (int i = 0; i < SlotCount; i++) begin
      if (!match && ident_q == TblId[i]) begin
        match = 1'b1;
        slot  = SlotW'(i);
      end
    end
  end

  // Raw extraction, limit selection and scaling to tenths.
  always_comb begin
    len_ok = (length_q == TblLen[slot]);
    raw    = TblWide[slot] ? {byte0_q, byte1_q} : {8'd0, byte0_q};
    case (slot)
      SLOT_RPM:     limit = rpm_limit_q;
      SLOT_SPEED:   limit = speed_limit_q;
      SLOT_CHARGE:  limit = {8'd0, charge_limit_q};
      SLOT_VOLTAGE: limit = voltage_limit_q;
      default:      limit = {8'd0, temp_limit_q};
    endcase
    over   = (raw > limit);
    // Times ten as eight times plus two times.
    scaled = ({4'd0, raw} << 3) + ({4'd0, raw} << 1);
    value  = TblX10[slot] ? scaled : {4'd0, raw};
  end

  // Outcome and next stored values.
  always_comb begin
    rpm_d        = rpm_q;
    rpm_warn_d   = rpm_warn_q;
    speed_d      = speed_q;
    speed_warn_d = speed_warn_q;
    charge_d     = charge_q;
    voltage_d    = voltage_q;
    temp_d       = temp_q;
    if (!match) begin
      outcome = OUTCOME_UNKNOWN;
    end else if (!len_ok) begin
      outcome = OUTCOME_LEN_ERR;
    end else begin
      outcome = over ? OUTCOME_OUT_RANGE : OUTCOME_IN_RANGE;
      case (slot)
        SLOT_RPM: begin
          rpm_d      = value;
          rpm_warn_d = over;
        end
        SLOT_SPEED: begin
          speed_d      = value[15:0];
          speed_warn_d = over;
        end
        SLOT_CHARGE:  charge_d  = value[11:0];
        SLOT_VOLTAGE: voltage_d = value[15:0];
        default:      temp_d    = value[11:0];
      endcase
    end
  end

  // Result packing, first field in the lowest bits.
  always_comb begin
    result = {1'b0, temp_d, voltage_d, charge_d, speed_warn_d, speed_d, rpm_warn_d, rpm_d,
              (match && len_ok) ? value : {ValueW{1'b0}},
              match ? slot : {SlotW{1'b0}},
              outcome};
  end

  // State update and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      rpm_q        <= '0;
      rpm_warn_q   <= 1'b0;
      speed_q      <= '0;
      speed_warn_q <= 1'b0;
      charge_q     <= '0;
      voltage_q    <= '0;
      temp_q       <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        rpm_q        <= rpm_d;
        rpm_warn_q   <= rpm_warn_d;
        speed_q      <= speed_d;
        speed_warn_q <= speed_warn_d;
        charge_q     <= charge_d;
        voltage_q    <= voltage_d;
        temp_q       <= temp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An unknown identifier reports slot zero and no value.
  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == OUTCOME_UNKNOWN) |->
      (m_axis_tdata[24:2] == '0))
    else $error("unknown identifier result carries a slot or value");

  // A length mismatch reports no value.
  a_len_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == OUTCOME_LEN_ERR) |->
      (m_axis_tdata[24:5] == '0))
    else $error("length mismatch result carries a value");

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while the result register is empty");

  // Stored values change only when an item moves into the result register.
  a_store_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(rpm_q) && $stable(speed_q) && $stable(temp_q))
    else $error("stored value changed without a transaction");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for can_signal_decoder: drives frames on the slave stream,
// checks every decoded result against a predictor and reprograms the limit registers.
// Depends on cansd_pkg and can_signal_decoder.
module tb_top;
  import cansd_pkg::*;

  // Identifiers of the signal table.
  localparam logic [IdentW-1:0] IdRpm     = 11'h101;
  localparam logic [IdentW-1:0] IdSpeed   = 11'h102;
  localparam logic [IdentW-1:0] IdCharge  = 11'h103;
  localparam logic [IdentW-1:0] IdVoltage = 11'h104;
  localparam logic [IdentW-1:0] IdTemp    = 11'h105;

  localparam int IdleLimit     = 1000;
  localparam int ItemsPerPhase = 175;
  localparam int PhaseCount    = 7;

  // Limit settings used by the configuration phases.
  typedef enum int {
    LIM_RESET,
    LIM_ZERO,
    LIM_MAX,
    LIM_RANDOM,
    LIM_LOW
  } limit_mode_e;

  // One received frame, first field in the lowest bits.
  typedef struct packed {
    logic               pad;
    logic [ByteW-1:0]   second_byte;
    logic [ByteW-1:0]   first_byte;
    logic [LengthW-1:0] frame_length;
    logic [IdentW-1:0]  frame_ident;
  } frame_t;

  // One decoded result, first field in the lowest bits.
  typedef struct packed {
    logic              pad;
    logic [11:0]       temp_now;
    logic [15:0]       voltage_now;
    logic [11:0]       charge_now;
    logic              speed_flag;
    logic [15:0]       speed_now;
    logic              rpm_flag;
    logic [ValueW-1:0] rpm_now;
    logic [ValueW-1:0] value_tenths;
    logic [SlotW-1:0]  signal_slot;
    logic [1:0]        outcome;
  } decoded_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int idle_cycles = 0;

  can_signal_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a period of 10 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [IdentW-1:0] slot_ident(slot_e s);
    case (s)
      SLOT_RPM:     return IdRpm;
      SLOT_SPEED:   return IdSpeed;
      SLOT_CHARGE:  return IdCharge;
      SLOT_VOLTAGE: return IdVoltage;
      default:      return IdTemp;
    endcase
  endfunction

  // Charge and temperature are one-byte signals, the rest take two bytes.
  function automatic logic [LengthW-1:0] slot_len(slot_e s);
    return (s == SLOT_CHARGE || s == SLOT_TEMP) ? 4'd1 : 4'd2;
  endfunction

  function automatic logic [15:0] default_limit(slot_e s);
    case (s)
      SLOT_RPM:     return RpmLimitReset;
      SLOT_SPEED:   return SpeedLimitReset;
      SLOT_CHARGE:  return {8'h00, ChargeLimitReset};
      SLOT_VOLTAGE: return VoltageLimitReset;
      default:      return {8'h00, TempLimitReset};
    endcase
  endfunction

  // Predicts the decoder's results and keeps them in order of arrival.
  class decode_scoreboard;
    logic [15:0]       lim [SlotCount];
    logic [ValueW-1:0] rpm_val;
    logic              rpm_warn;
    logic [15:0]       speed_val;
    logic              speed_warn;
    logic [11:0]       charge_val;
    logic [15:0]       voltage_val;
    logic [11:0]       temp_val;
    decoded_t          decoded_q[$];
    int                errors = 0;

    // State after reset: default limits, nothing stored.
    function void clear();
      for (int i = 0; i < SlotCount; i++) lim[i] = default_limit(slot_e'(i));
      rpm_val = '0;
      rpm_warn = 1'b0;
      speed_val = '0;
      speed_warn = 1'b0;
      charge_val = '0;
      voltage_val = '0;
      temp_val = '0;
      decoded_q.delete();
    endfunction

    // Byte-wide limits keep only their low eight bits.
    function void set_limit(slot_e s, logic [DataW-1:0] data);
      if (s == SLOT_CHARGE || s == SLOT_TEMP) lim[s] = {8'h00, data[7:0]};
      else lim[s] = data[15:0];
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // Decodes one accepted frame and queues the result it must produce.
    function void note_frame(frame_t f);
      decoded_t          d;
      slot_e             s;
      logic              found;
      logic              wide;
      logic [15:0]       raw;
      logic              over;
      logic [ValueW-1:0] value;
      d = '0;
      s = SLOT_RPM;
      found = 1'b1;
      case (f.frame_ident)
        IdRpm:     s = SLOT_RPM;
        IdSpeed:   s = SLOT_SPEED;
        IdCharge:  s = SLOT_CHARGE;
        IdVoltage: s = SLOT_VOLTAGE;
        IdTemp:    s = SLOT_TEMP;
        default:   found = 1'b0;
      endcase
      wide = (s == SLOT_RPM || s == SLOT_SPEED || s == SLOT_VOLTAGE);
      d.outcome = OUTCOME_UNKNOWN;
      d.signal_slot = s;
      if (found) begin
        if (f.frame_length != (wide ? 4'd2 : 4'd1)) begin
          d.outcome = OUTCOME_LEN_ERR;
        end else begin
          raw = wide ? {f.first_byte, f.second_byte} : {8'h00, f.first_byte};
          over = (raw > lim[s]);
          // Speed and voltage already arrive in tenths; the others are whole units.
          if (s == SLOT_SPEED || s == SLOT_VOLTAGE) value = {4'h0, raw};
          else value = 20'(raw) * 20'd10;
          d.outcome = over ? OUTCOME_OUT_RANGE : OUTCOME_IN_RANGE;
          d.value_tenths = value;
          case (s)
            SLOT_RPM: begin
              rpm_val = value;
              rpm_warn = over;
            end
            SLOT_SPEED: begin
              speed_val = value[15:0];
              speed_warn = over;
            end
            SLOT_CHARGE:  charge_val = value[11:0];
            SLOT_VOLTAGE: voltage_val = value[15:0];
            default:      temp_val = value[11:0];
          endcase
        end
      end
      d.rpm_now = rpm_val;
      d.rpm_flag = rpm_warn;
      d.speed_now = speed_val;
      d.speed_flag = speed_warn;
      d.charge_now = charge_val;
      d.voltage_now = voltage_val;
      d.temp_now = temp_val;
      decoded_q.push_back(d);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [ValueW-1:0] got, logic [ValueW-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(logic [OutDataW-1:0] data);
      decoded_t got;
      decoded_t want;
      got = data;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing predicted", data));
        return;
      end
      want = decoded_q.pop_front();
      compare_field("outcome", got.outcome, want.outcome);
      compare_field("signal_slot", got.signal_slot, want.signal_slot);
      compare_field("value_tenths", got.value_tenths, want.value_tenths);
      compare_field("rpm_now", got.rpm_now, want.rpm_now);
      compare_field("rpm_flag", got.rpm_flag, want.rpm_flag);
      compare_field("speed_now", got.speed_now, want.speed_now);
      compare_field("speed_flag", got.speed_flag, want.speed_flag);
      compare_field("charge_now", got.charge_now, want.charge_now);
      compare_field("voltage_now", got.voltage_now, want.voltage_now);
      compare_field("temp_now", got.temp_now, want.temp_now);
      compare_field("padding", got.pad, 1'b0);
    endtask
  endclass

  decode_scoreboard sb;

  function automatic frame_t make_frame(logic [IdentW-1:0] ident, logic [LengthW-1:0] len,
                                        logic [ByteW-1:0] b0, logic [ByteW-1:0] b1);
    frame_t f;
    f = '0;
    f.frame_ident = ident;
    f.frame_length = len;
    f.first_byte = b0;
    f.second_byte = b1;
    return f;
  endfunction

  // Mostly well-formed frames of the table, some aimed at the limit, plus noise.
  function automatic frame_t random_frame();
    frame_t      f;
    int          kind;
    slot_e       s;
    logic [16:0] raw;
    logic [16:0] top;
    f = make_frame(IdentW'($urandom_range(0, 2047)), LengthW'($urandom_range(0, 15)),
                   ByteW'($urandom), ByteW'($urandom));
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      s = slot_e'($urandom_range(0, SlotCount - 1));
      f.frame_ident = slot_ident(s);
      if (kind < 70) f.frame_length = slot_len(s);
      // Raw value one below, at or one above the limit.
      if (kind < 22) begin
        top = (slot_len(s) == 4'd2) ? 17'h0FFFF : 17'h000FF;
        raw = {1'b0, sb.lim[s]} + 17'($urandom_range(0, 2));
        if (raw != 17'd0) raw = raw - 17'd1;
        if (raw > top) raw = top;
        if (slot_len(s) == 4'd2) {f.first_byte, f.second_byte} = raw[15:0];
        else f.first_byte = raw[7:0];
      end
    end
    return f;
  endfunction

  // Offers one frame after a random gap and waits for the transaction.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= f;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_frame(f);
  endtask

  // Stops offering frames and waits until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [DataW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input int idx, output logic [DataW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrW'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads every limit register back and compares it with the predicted value.
  task automatic verify_limits();
    logic [DataW-1:0] data;
    for (int i = 0; i < SlotCount; i++) begin
      apb_read(i, data);
      if (data !== {16'h0000, sb.lim[i]})
        sb.report_mismatch($sformatf("limit register %0d reads %h, expected %h",
                                     i, data, {16'h0000, sb.lim[i]}));
    end
  endtask

  // Writes all limit registers with one setting; upper bits carry noise.
  task automatic program_limits(input limit_mode_e mode);
    logic [15:0]      value;
    logic [DataW-1:0] data;
    for (int i = 0; i < SlotCount; i++) begin
      case (mode)
        LIM_ZERO:   value = 16'h0000;
        LIM_MAX:    value = 16'hFFFF;
        LIM_RANDOM: value = 16'($urandom);
        LIM_LOW:    value = 16'($urandom_range(0, 300));
        default:    value = default_limit(slot_e'(i));
      endcase
      data = {16'($urandom), value};
      apb_write(i, data);
      sb.set_limit(slot_e'(i), data);
    end
    verify_limits();
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      send_frame(random_frame());
    end
  endtask

  // Frames at the field extremes, at each limit and for every outcome.
  task automatic run_directed();
    send_frame(make_frame(IdRpm, 4'd2, 8'h00, 8'h00));
    send_frame(make_frame(IdRpm, 4'd2, 8'h27, 8'h10));
    send_frame(make_frame(IdRpm, 4'd2, 8'h27, 8'h11));
    send_frame(make_frame(IdRpm, 4'd2, 8'hFF, 8'hFF));
    send_frame(make_frame(IdSpeed, 4'd2, 8'h04, 8'hB0));
    send_frame(make_frame(IdSpeed, 4'd2, 8'h04, 8'hB1));
    send_frame(make_frame(IdSpeed, 4'd2, 8'hFF, 8'hFF));
    // One-byte signals ignore the second data byte.
    send_frame(make_frame(IdCharge, 4'd1, 8'd100, 8'hFF));
    send_frame(make_frame(IdCharge, 4'd1, 8'd101, 8'h00));
    send_frame(make_frame(IdCharge, 4'd1, 8'hFF, 8'h5A));
    send_frame(make_frame(IdVoltage, 4'd2, 8'h03, 8'hE8));
    send_frame(make_frame(IdVoltage, 4'd2, 8'h03, 8'hE9));
    send_frame(make_frame(IdVoltage, 4'd2, 8'h00, 8'h00));
    send_frame(make_frame(IdTemp, 4'd1, 8'd150, 8'hAA));
    send_frame(make_frame(IdTemp, 4'd1, 8'd151, 8'hFF));
    send_frame(make_frame(IdTemp, 4'd1, 8'hFF, 8'h00));
    send_frame(make_frame(IdTemp, 4'd1, 8'h00, 8'hFF));
    // Known identifiers with the wrong length, including the top codes.
    send_frame(make_frame(IdRpm, 4'd1, 8'h12, 8'h34));
    send_frame(make_frame(IdCharge, 4'd2, 8'h10, 8'h10));
    send_frame(make_frame(IdTemp, 4'd0, 8'hFF, 8'hFF));
    send_frame(make_frame(IdSpeed, 4'd15, 8'h00, 8'h01));
    send_frame(make_frame(IdVoltage, 4'd8, 8'hFF, 8'hFF));
    // Identifiers outside the table.
    send_frame(make_frame(11'h000, 4'd0, 8'h00, 8'h00));
    send_frame(make_frame(11'h7FF, 4'd15, 8'hFF, 8'hFF));
    send_frame(make_frame(11'h100, 4'd2, 8'h01, 8'h02));
    send_frame(make_frame(11'h106, 4'd1, 8'h80, 8'h80));
  endtask

  // Main sequence: reset, directed frames, then random frames under several limit settings.
  initial begin
    limit_mode_e phase_mode [PhaseCount];
    phase_mode = '{LIM_RESET, LIM_ZERO, LIM_MAX, LIM_RANDOM, LIM_LOW, LIM_RANDOM, LIM_RESET};
    sb = new;
    sb.clear();
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    verify_limits();
    run_directed();
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) begin
        drain();
        program_limits(phase_mode[ph]);
      end
      run_random(ItemsPerPhase);
    end
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, with calm stretches, then one transaction each.
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata);
      taken++;
      if (taken % 50 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
